// ----- src/pad_to_hid_report_mapper_core_macros.svh -----
// Assertion macros for the pad-to-HID report mapper RTL.
// Expects signals clk and rst_n in the including module.
`ifndef PAD_TO_HID_REPORT_MAPPER_CORE_MACROS_SVH
`define PAD_TO_HID_REPORT_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PTHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PTHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pthm_pkg.sv -----
// Package for the pad-to-HID report mapper: constants, config indexes,
// pipeline control struct. No dependencies.
`timescale 1ns / 1ps

package pthm_pkg;

  localparam int NUM_ANALOG  = 3;
  localparam int NUM_DIGITAL = 8;
  localparam int NUM_CTRL    = NUM_ANALOG + NUM_DIGITAL;
  localparam int NUM_AXES    = 4;
  localparam int DIV_STEPS   = 8;
  // stage 0 clamps, stages 1..DIV_STEPS each resolve one quotient bit
  localparam int NUM_STAGES  = DIV_STEPS + 1;

  localparam logic [3:0] NIB_BUTTON     = 4'h0;
  localparam logic [3:0] NIB_AXIS_FIRST = 4'h3;
  localparam logic [3:0] NIB_AXIS_LAST  = 4'h6;

  localparam logic [7:0] TWIST_FLIP   = 8'h80;
  localparam logic [7:0] AXIS_PRESSED = 8'h80;
  localparam logic [7:0] AXIS_IDLE    = 8'h00;

  localparam logic [23:0] RST_ANALOG_MAP  = 24'hFF_FFFF;
  localparam logic [63:0] RST_DIGITAL_MAP = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [23:0] RST_LOWER_THR   = 24'h00_0000;
  localparam logic [23:0] RST_UPPER_THR   = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    CFG_ANALOG_MAP  = 2'd0,
    CFG_DIGITAL_MAP = 2'd1,
    CFG_LOWER_THR   = 2'd2,
    CFG_UPPER_THR   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [NUM_STAGES:0]   load;       // per-stage load, top bit is the output register
    logic [NUM_STAGES-1:0] valid;
    logic                  out_valid;
  } pipe_ctl_t;

endpackage

// ----- src/pthm_pipe_ctrl.sv -----
// Valid bits and load enables for the mapper pipeline and output register.
// Depends on pthm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pad_to_hid_report_mapper_core_macros.svh"

module pthm_pipe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               out_tready,
  output pthm_pkg::pipe_ctl_t ctl
);
  import pthm_pkg::*;

  logic [NUM_STAGES-1:0] valid_r;
  logic                  out_valid_r;
  logic [NUM_STAGES:0]   load;

  // a stage loads when empty or when its word moves on; bubbles collapse
  always_comb begin
    load[NUM_STAGES] = !out_valid_r || out_tready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      load[i] = !valid_r[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (load[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
      if (load[NUM_STAGES]) begin
        out_valid_r <= valid_r[NUM_STAGES-1];
      end
    end
  end

  assign ctl.load      = load;
  assign ctl.valid     = valid_r;
  assign ctl.out_valid = out_valid_r;

  `PTHM_ASSERT_NXT(a_accept_fills, in_tvalid && load[0], valid_r[0], "accepted word lost at entry")
  `PTHM_ASSERT_IMP(a_stall_only_full, !load[0], (&valid_r) && out_valid_r, "input stalled with a bubble")
  `PTHM_ASSERT_IMP(a_out_source, $rose(out_valid_r), $past(valid_r[NUM_STAGES-1]), "output valid without source")

endmodule

// ----- src/pthm_analog_lane.sv -----
// One analog lane: threshold clamp, then an 8-stage restoring divider
// giving (-(d*128/range)) mod 256. Depends on pthm_pkg.
`timescale 1ns / 1ps

module pthm_analog_lane (
  input  logic                clk,
  input  pthm_pkg::pipe_ctl_t ctl,
  input  logic [7:0]          raw,
  input  logic [7:0]          lo,
  input  logic [7:0]          hi,
  output logic [7:0]          val
);
  import pthm_pkg::*;

  logic [7:0] rem_r [NUM_STAGES];
  logic [7:0] quo_r [NUM_STAGES];
  logic [7:0] rng_r [NUM_STAGES];
  logic       dz_r  [NUM_STAGES];

  logic [7:0] v_hi;
  logic [7:0] v_cl;
  logic [7:0] d;

  // crossed thresholds clamp to lo, so d is zero
  always_comb begin
    v_hi = (raw > hi) ? hi : raw;
    v_cl = (v_hi < lo) ? lo : v_hi;
    d    = v_cl - lo;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      rem_r[0] <= d;
      quo_r[0] <= '0;
      rng_r[0] <= hi - lo;
      dz_r[0]  <= (d == 8'd0);
    end
  end

  for (genvar j = 1; j < NUM_STAGES; j++) begin : g_div
    logic [8:0] trial;
    logic       qbit;
    logic [8:0] diff;

    // first step tests the 128 weight (d equal to range), later steps shift
    if (j == 1) begin : g_first
      assign trial = {1'b0, rem_r[j-1]};
    end else begin : g_next
      assign trial = {rem_r[j-1], 1'b0};
    end

    assign qbit = (trial >= {1'b0, rng_r[j-1]});
    assign diff = trial - {1'b0, rng_r[j-1]};

    always_ff @(posedge clk) begin
      if (ctl.load[j]) begin
        rem_r[j] <= qbit ? diff[7:0] : trial[7:0];
        quo_r[j] <= {quo_r[j-1][6:0], qbit};
        rng_r[j] <= rng_r[j-1];
        dz_r[j]  <= dz_r[j-1];
      end
    end
  end

  // zero d covers zero range too
  assign val = dz_r[NUM_STAGES-1] ? 8'd0 : (8'd0 - quo_r[NUM_STAGES-1]);

endmodule

// ----- src/pthm_merge.sv -----
// Merge stage: routes the analog lane values and digital bits through the
// mapping bytes in control order into the output register. Depends on pthm_pkg.
`timescale 1ns / 1ps

module pthm_merge (
  input  logic                clk,
  input  pthm_pkg::pipe_ctl_t ctl,
  input  logic [7:0]          val_i,
  input  logic [7:0]          val_ii,
  input  logic [7:0]          val_l,
  input  logic [7:0]          dig_a,
  input  logic [7:0]          dig_b,
  input  logic [7:0]          twist,
  input  logic [23:0]         analog_map,
  input  logic [63:0]         digital_map,
  output logic [15:0]         buttons,
  output logic [7:0]          axis_x,
  output logic [7:0]          axis_z,
  output logic [7:0]          axis_rx,
  output logic [7:0]          axis_ry,
  output logic [7:0]          axis_rz
);
  import pthm_pkg::*;

  logic [7:0]  map_b   [NUM_CTRL];
  logic        press_b [NUM_CTRL];
  logic [7:0]  aval_b  [NUM_CTRL];
  logic [15:0] btn_nxt;
  logic [7:0]  ax_nxt  [NUM_AXES];
  logic [3:0]  nib;
  logic [3:0]  ax_off;

  logic [15:0] buttons_r;
  logic [7:0]  axis_x_r;
  logic [7:0]  ax_r [NUM_AXES];

  always_comb begin
    map_b[0] = analog_map[7:0];
    map_b[1] = analog_map[15:8];
    map_b[2] = analog_map[23:16];
    aval_b[0] = val_i;
    aval_b[1] = val_ii;
    aval_b[2] = val_l;
    for (int a = 0; a < NUM_ANALOG; a++) begin
      press_b[a] = (aval_b[a] != 8'd0);
    end
    for (int k = 0; k < NUM_DIGITAL; k++) begin
      map_b[NUM_ANALOG+k] = digital_map[8*k +: 8];
    end
    // left, down, right, up, start on byte a bits 7..3; a, b, r on byte b bits 5..3
    for (int k = 0; k < 5; k++) begin
      press_b[NUM_ANALOG+k] = !dig_a[7-k];
    end
    for (int k = 0; k < 3; k++) begin
      press_b[NUM_ANALOG+5+k] = !dig_b[5-k];
    end
    for (int k = 0; k < NUM_DIGITAL; k++) begin
      aval_b[NUM_ANALOG+k] = press_b[NUM_ANALOG+k] ? AXIS_PRESSED : AXIS_IDLE;
    end
  end

  // later controls overwrite earlier ones
  always_comb begin
    btn_nxt = '0;
    for (int x = 0; x < NUM_AXES; x++) begin
      ax_nxt[x] = '0;
    end
    nib    = '0;
    ax_off = '0;
    for (int k = 0; k < NUM_CTRL; k++) begin
      nib    = map_b[k][7:4];
      ax_off = nib - NIB_AXIS_FIRST;
      if (nib == NIB_BUTTON) begin
        btn_nxt[map_b[k][3:0]] = press_b[k];
      end else if (nib >= NIB_AXIS_FIRST && nib <= NIB_AXIS_LAST) begin
        ax_nxt[ax_off[1:0]] = aval_b[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[NUM_STAGES]) begin
      buttons_r <= btn_nxt;
      axis_x_r  <= twist ^ TWIST_FLIP;
      for (int x = 0; x < NUM_AXES; x++) begin
        ax_r[x] <= ax_nxt[x];
      end
    end
  end

  assign buttons = buttons_r;
  assign axis_x  = axis_x_r;
  assign axis_z  = ax_r[0];
  assign axis_rx = ax_r[1];
  assign axis_ry = ax_r[2];
  assign axis_rz = ax_r[3];

endmodule

// ----- src/pad_to_hid_report_mapper_core.sv -----
// Top level of the pad-to-HID report mapper: config registers, three analog
// lanes, digital/twist delay line, merge stage. Uses pthm_pkg and all pthm_ modules.
//
//  port group   dir  word layout (lsb first)
//  in_          in   digital_byte_a, digital_byte_b, twist, analog_i, analog_ii, analog_l
//  out_         out  buttons, axis_x, axis_z, axis_rx, axis_ry, axis_rz
//  cfg_         in   write-only: analog_mapping, digital_mapping, lower/upper_thresholds
//
// One word per cycle sustained while the output is not stalled; an accepted word passes
// through the clamp stage, the 8-stage divider in each analog lane, and the output
// register before out_tvalid. Reset (rst_n low, synchronous) empties the pipeline and
// restores register defaults. Bubbles collapse under an output stall; in_tready drops
// only when all stages and the output register hold words.
`timescale 1ns / 1ps

module pad_to_hid_report_mapper_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // digital_byte_a, digital_byte_b, twist, analog_i, analog_ii, analog_l
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // buttons[15:0], axis_x, axis_z, axis_rx, axis_ry, axis_rz
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);
  import pthm_pkg::*;

  logic [23:0] analog_map_r;
  logic [63:0] digital_map_r;
  logic [23:0] lower_thr_r;
  logic [23:0] upper_thr_r;

  pipe_ctl_t ctl;

  logic [7:0] dig_a_r [NUM_STAGES];
  logic [7:0] dig_b_r [NUM_STAGES];
  logic [7:0] twist_r [NUM_STAGES];

  logic [7:0] val_i;
  logic [7:0] val_ii;
  logic [7:0] val_l;

  logic [15:0] buttons;
  logic [7:0]  axis_x;
  logic [7:0]  axis_z;
  logic [7:0]  axis_rx;
  logic [7:0]  axis_ry;
  logic [7:0]  axis_rz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      analog_map_r  <= RST_ANALOG_MAP;
      digital_map_r <= RST_DIGITAL_MAP;
      lower_thr_r   <= RST_LOWER_THR;
      upper_thr_r   <= RST_UPPER_THR;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ANALOG_MAP:  analog_map_r  <= cfg_wdata[23:0];
        CFG_DIGITAL_MAP: digital_map_r <= cfg_wdata;
        CFG_LOWER_THR:   lower_thr_r   <= cfg_wdata[23:0];
        CFG_UPPER_THR:   upper_thr_r   <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  pthm_pipe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  assign in_tready  = ctl.load[0];
  assign out_tvalid = ctl.out_valid;

  // digital bytes and twist ride alongside the divider
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      dig_a_r[0] <= in_tdata[7:0];
      dig_b_r[0] <= in_tdata[15:8];
      twist_r[0] <= in_tdata[23:16];
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (ctl.load[i]) begin
        dig_a_r[i] <= dig_a_r[i-1];
        dig_b_r[i] <= dig_b_r[i-1];
        twist_r[i] <= twist_r[i-1];
      end
    end
  end

  pthm_analog_lane u_lane_i (
    .clk (clk),
    .ctl (ctl),
    .raw (in_tdata[31:24]),
    .lo  (lower_thr_r[7:0]),
    .hi  (upper_thr_r[7:0]),
    .val (val_i)
  );

  pthm_analog_lane u_lane_ii (
    .clk (clk),
    .ctl (ctl),
    .raw (in_tdata[39:32]),
    .lo  (lower_thr_r[15:8]),
    .hi  (upper_thr_r[15:8]),
    .val (val_ii)
  );

  pthm_analog_lane u_lane_l (
    .clk (clk),
    .ctl (ctl),
    .raw (in_tdata[47:40]),
    .lo  (lower_thr_r[23:16]),
    .hi  (upper_thr_r[23:16]),
    .val (val_l)
  );

  pthm_merge u_merge (
    .clk         (clk),
    .ctl         (ctl),
    .val_i       (val_i),
    .val_ii      (val_ii),
    .val_l       (val_l),
    .dig_a       (dig_a_r[NUM_STAGES-1]),
    .dig_b       (dig_b_r[NUM_STAGES-1]),
    .twist       (twist_r[NUM_STAGES-1]),
    .analog_map  (analog_map_r),
    .digital_map (digital_map_r),
    .buttons     (buttons),
    .axis_x      (axis_x),
    .axis_z      (axis_z),
    .axis_rx     (axis_rx),
    .axis_ry     (axis_ry),
    .axis_rz     (axis_rz)
  );

  assign out_tdata = {axis_rz, axis_ry, axis_rx, axis_z, axis_x, buttons};

endmodule
